// ===== hw/rtl/ssc_pkg.sv =====
package ssc_pkg;

	// Recognised command bytes.
	localparam logic [7:0] BYTE_STOP = 8'h36;
	localparam logic [7:0] BYTE_PING = 8'h30;
	localparam logic [7:0] BYTE_SCAN = 8'h34;
	localparam logic [7:0] BYTE_HOME = 8'h32;

	// Transmitted bytes.
	localparam logic [7:0] REPLY_PING  = 8'h31;
	localparam logic [7:0] REPLY_DONE  = 8'h33;
	localparam logic [7:0] SCAN_HEADER = 8'hAA;

	localparam logic [15:0] STEP_LIMIT_RESET = 16'd10000;

	// Depth of the job queue between the front and back parts.
	localparam int JOB_DEPTH = 4;

	typedef enum logic [2:0] {
		CMD_NONE = 3'd0,
		CMD_STOP = 3'd1,
		CMD_PING = 3'd2,
		CMD_SCAN = 3'd3,
		CMD_HOME = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		JOB_PING      = 2'd0,
		JOB_SCAN      = 2'd1,
		JOB_HOME_STEP = 2'd2,
		JOB_HOME_DONE = 2'd3
	} job_kind_t;

	// One tick's worth of output work.
	typedef struct packed {
		job_kind_t   kind;
		logic        step;
		logic [7:0]  sample_hi;
		logic [7:0]  sample_lo;
	} job_t;

	// One result beat.
	typedef struct packed {
		logic        byte_valid;
		logic [7:0]  tx_byte;
		logic        step_pulse;
		logic        override_active;
		logic        pen_lift_active;
		logic        last;
	} result_t;

endpackage

// ===== hw/rtl/ssc_front.sv =====
module ssc_front #(
	parameter int SAMPLE_BITS = 12
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   accept,
	input  logic                   kind,
	input  logic [7:0]             command_byte,
	input  logic                   left_limit_clear,
	input  logic                   right_limit_clear,
	input  logic [SAMPLE_BITS-1:0] adc_sample,
	input  logic                   cfg_we,
	input  logic [15:0]            cfg_wdata,
	output logic                   job_push,
	output ssc_pkg::job_t          job
);
	import ssc_pkg::*;

	cmd_t        pending_q, pending_d;
	logic [15:0] step_count_q, step_count_d;
	logic        homing_q, homing_d;
	logic [15:0] step_limit_q;
	logic [15:0] home_base;
	logic [15:0] sample_ext;
	logic        job_valid;

	assign sample_ext = 16'(adc_sample);
	// Homing starts from a cleared counter on its first tick.
	assign home_base  = homing_q ? step_count_q : 16'd0;

	always_comb begin
		pending_d     = pending_q;
		step_count_d  = step_count_q;
		homing_d      = homing_q;
		job_valid     = 1'b0;
		job.kind      = JOB_PING;
		job.step      = 1'b0;
		job.sample_hi = sample_ext[15:8];
		job.sample_lo = sample_ext[7:0];
		if (!kind) begin
			if (!homing_q) begin
				unique case (command_byte)
					BYTE_STOP: pending_d = CMD_STOP;
					BYTE_PING: pending_d = CMD_PING;
					BYTE_SCAN: pending_d = CMD_SCAN;
					BYTE_HOME: pending_d = CMD_HOME;
					default:   pending_d = pending_q;
				endcase
			end
		end else begin
			unique case (pending_q)
				CMD_STOP: begin
					pending_d    = CMD_NONE;
					step_count_d = 16'd0;
				end
				CMD_PING: begin
					pending_d = CMD_NONE;
					job_valid = 1'b1;
					job.kind  = JOB_PING;
				end
				CMD_SCAN: begin
					job_valid    = 1'b1;
					job.kind     = JOB_SCAN;
					job.step     = (step_count_q <= step_limit_q) &&
						left_limit_clear && right_limit_clear;
					step_count_d = step_count_q + 16'd1;
				end
				CMD_HOME: begin
					job_valid = 1'b1;
					if (right_limit_clear) begin
						job.kind     = JOB_HOME_STEP;
						job.step     = (home_base <= step_limit_q) && left_limit_clear;
						step_count_d = home_base + 16'd1;
						homing_d     = 1'b1;
					end else begin
						job.kind     = JOB_HOME_DONE;
						step_count_d = 16'd0;
						pending_d    = CMD_NONE;
						homing_d     = 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign job_push = accept && kind && job_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q    <= CMD_NONE;
			step_count_q <= 16'd0;
			homing_q     <= 1'b0;
			step_limit_q <= STEP_LIMIT_RESET;
		end else begin
			if (accept) begin
				pending_q    <= pending_d;
				step_count_q <= step_count_d;
				homing_q     <= homing_d;
			end
			if (cfg_we) begin
				step_limit_q <= cfg_wdata;
			end
		end
	end

endmodule

// ===== hw/rtl/ssc_fifo.sv =====
module ssc_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  ssc_pkg::job_t wr_job,
	output logic          full,
	input  logic          rd_en,
	output ssc_pkg::job_t rd_job,
	output logic          empty
);
	import ssc_pkg::*;

	localparam int PTR_W = (JOB_DEPTH > 1) ? $clog2(JOB_DEPTH) : 1;
	localparam int CNT_W = $clog2(JOB_DEPTH + 1);

	job_t             mem [JOB_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr, do_rd;

	assign full   = (count_q == CNT_W'(JOB_DEPTH));
	assign empty  = (count_q == '0);
	assign do_wr  = wr_en && !full;
	assign do_rd  = rd_en && !empty;
	assign rd_job = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(JOB_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(JOB_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// ===== hw/rtl/ssc_back.sv =====
module ssc_back (
	input  logic             clk,
	input  logic             arst_n,
	input  ssc_pkg::job_t    job,
	input  logic             job_empty,
	output logic             job_pop,
	input  logic             pop,
	output logic             empty,
	output ssc_pkg::result_t result
);
	import ssc_pkg::*;

	logic [1:0] beat_q;
	logic       final_beat;
	logic       take;

	assign empty      = job_empty;
	assign take       = pop && !job_empty;
	assign final_beat = (job.kind == JOB_SCAN) ? (beat_q == 2'd2) : 1'b1;
	assign job_pop    = take && final_beat;

	always_comb begin
		result.byte_valid      = 1'b1;
		result.tx_byte         = 8'h00;
		result.step_pulse      = 1'b0;
		result.override_active = 1'b0;
		result.pen_lift_active = 1'b0;
		result.last            = final_beat;
		unique case (job.kind)
			JOB_PING: begin
				result.tx_byte = REPLY_PING;
			end
			JOB_SCAN: begin
				result.override_active = 1'b1;
				result.pen_lift_active = 1'b1;
				unique case (beat_q)
					2'd0: begin
						result.tx_byte    = SCAN_HEADER;
						result.step_pulse = job.step;
					end
					2'd1:    result.tx_byte = job.sample_hi;
					default: result.tx_byte = job.sample_lo;
				endcase
			end
			JOB_HOME_STEP: begin
				result.byte_valid      = 1'b0;
				result.step_pulse      = job.step;
				result.override_active = 1'b1;
			end
			JOB_HOME_DONE: begin
				result.tx_byte         = REPLY_DONE;
				result.override_active = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_q <= 2'd0;
		end else if (take) begin
			beat_q <= final_beat ? 2'd0 : beat_q + 2'd1;
		end
	end

endmodule

// ===== hw/rtl/sweep_scan_controller.sv =====
// Sweep scanner command decoder and control loop.
// Input channel (push/full): each beat is either a received command byte
// (kind low) or a control loop tick (kind high) carrying the limit switch
// levels and the converter sample. A beat is taken when push is high and
// full is low; one beat can be taken in every cycle.
// Result channel (empty/pop): the oldest result beat sits on the result ports
// while empty is low and leaves when pop is high. A ping, home step or home
// done tick gives one beat, a scan tick gives three (header, sample high byte,
// sample low byte), and stop ticks, idle ticks and command bytes give none.
// A tick's job is registered into the queue; its first beat shows once older
// jobs have left; the beats of a scan follow one per cycle while pop is held high.
// The front part updates the command and step state in the cycle a beat is
// taken, so the input rate is one item per cycle while full is low. Its jobs
// wait in a four-entry queue; while the receiver stalls the block keeps taking
// items until four ticks with results are queued, and then full rises.
// Configuration: cfg_we writes cfg_wdata into the step limit.
// Reset: the queue empties, no command is pending, the step counter is zero
// and the step limit returns to 10000.
module sweep_scan_controller #(
	parameter int SAMPLE_BITS = 12
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	output logic                   full,
	input  logic                   kind,
	input  logic [7:0]             command_byte,
	input  logic                   left_limit_clear,
	input  logic                   right_limit_clear,
	input  logic [SAMPLE_BITS-1:0] adc_sample,
	input  logic                   cfg_we,
	input  logic [15:0]            cfg_wdata,
	output logic                   empty,
	input  logic                   pop,
	output logic                   byte_valid,
	output logic [7:0]             tx_byte,
	output logic                   step_pulse,
	output logic                   override_active,
	output logic                   pen_lift_active,
	output logic                   last
);
	import ssc_pkg::*;

	logic    accept;
	logic    job_push;
	job_t    front_job;
	job_t    queue_job;
	logic    queue_empty;
	logic    queue_pop;
	result_t result;

	// Full comes straight from the job queue, so a command byte is also held
	// off while the queue is full; that keeps the accept condition simple.
	assign accept = push && !full;

	ssc_front #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.accept            (accept),
		.kind              (kind),
		.command_byte      (command_byte),
		.left_limit_clear  (left_limit_clear),
		.right_limit_clear (right_limit_clear),
		.adc_sample        (adc_sample),
		.cfg_we            (cfg_we),
		.cfg_wdata         (cfg_wdata),
		.job_push          (job_push),
		.job               (front_job)
	);

	ssc_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (job_push),
		.wr_job (front_job),
		.full   (full),
		.rd_en  (queue_pop),
		.rd_job (queue_job),
		.empty  (queue_empty)
	);

	// The back part walks through the beats of the job at the queue head and
	// releases the job with its final beat.
	ssc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (queue_job),
		.job_empty (queue_empty),
		.job_pop   (queue_pop),
		.pop       (pop),
		.empty     (empty),
		.result    (result)
	);

	assign byte_valid      = result.byte_valid;
	assign tx_byte         = result.tx_byte;
	assign step_pulse      = result.step_pulse;
	assign override_active = result.override_active;
	assign pen_lift_active = result.pen_lift_active;
	assign last            = result.last;

endmodule

// ===== hw/rtl/ssc_checker.sv =====
module ssc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       empty,
	input logic       pop,
	input logic       byte_valid,
	input logic [7:0] tx_byte,
	input logic       step_pulse,
	input logic       override_active,
	input logic       pen_lift_active,
	input logic       last
);

	// A waiting beat that is not taken stays put.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(tx_byte) && $stable(last))
		else $error("result beat changed while stalled");

	// A beat without a byte is a home step: a single beat with override on.
	a_home_step: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !byte_valid |-> last && override_active && !pen_lift_active &&
		tx_byte == 8'h00)
		else $error("beat without byte is malformed");

	// Pen lift only comes with the scan override.
	a_pen: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && pen_lift_active |-> override_active && byte_valid)
		else $error("pen lift without override");

	// A step is only issued while scanning or homing drives override.
	a_step: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && step_pulse |-> override_active)
		else $error("step pulse without override");

	// A scan beat taken without being final is followed by another scan beat.
	a_scan_run: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && pop && pen_lift_active && !last |=> !empty && pen_lift_active)
		else $error("scan beats broken up");

endmodule

bind sweep_scan_controller ssc_checker u_ssc_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.empty           (empty),
	.pop             (pop),
	.byte_valid      (byte_valid),
	.tx_byte         (tx_byte),
	.step_pulse      (step_pulse),
	.override_active (override_active),
	.pen_lift_active (pen_lift_active),
	.last            (last)
);
